/* hdl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int MODE_W       = 2;
  localparam int COUNT_W      = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXTRACT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD    = 2'd3;  // behaves as peek

  localparam logic signed [KEY_W-1:0] EMPTY_VALUE = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_RD0,
    S_EX_RDLAST,
    S_EX_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMPR,
    S_DN_MOVE,
    S_PK_RD,
    S_PK_GET
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    status_t                 status;
    logic [COUNT_W-1:0]      count;
  } out_word_t;

endpackage

/* hdl/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/mhpq_seq.sv */
// ----------------------------------------------------------------------------
// mhpq_seq
// Heap sequencer: walks sift-up / sift-down one level at a time through the
// heap RAM, with a single shared signed comparator.
// ----------------------------------------------------------------------------
module mhpq_seq #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  mhpq_pkg::in_word_t          in_word,
  output logic                        busy,
  output logic                        out_valid,
  output mhpq_pkg::out_word_t         out_word,
  output logic                        ram_wr_en,
  output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
  output logic [mhpq_pkg::KEY_W-1:0]  ram_wr_data,
  output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
  input  logic [mhpq_pkg::KEY_W-1:0]  ram_rd_data
);

  import mhpq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = IW + 2;  // holds child index up to 2*CAPACITY

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [IW-1:0]           big_r, big_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] cand_r, cand_nxt;
  logic signed [KEY_W-1:0] value_r, value_nxt;
  logic                    moved_r, moved_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  logic signed [KEY_W-1:0] rd_key;
  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_gt;
  logic [IW-1:0]           pidx;
  logic [LW-1:0]           lidx, ridx, n_ext;

  assign rd_key = signed'(ram_rd_data);
  assign pidx   = (idx_r - IW'(1)) >> 1;
  assign lidx   = {1'b0, idx_r, 1'b1};
  assign ridx   = lidx + LW'(1);
  assign n_ext  = LW'(count_r);

  // shared comparator
  assign cmp_gt = cmp_a > cmp_b;

  always_comb begin
    unique case (state_r)
      S_UP_CMP:  begin cmp_a = key_r;  cmp_b = rd_key; end
      S_DN_CMPR: begin cmp_a = rd_key; cmp_b = cand_r; end
      default:   begin cmp_a = rd_key; cmp_b = key_r;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    big_r      <= big_nxt;
    key_r      <= key_nxt;
    cand_r     <= cand_nxt;
    value_r    <= value_nxt;
    moved_r    <= moved_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    big_nxt       = big_r;
    key_nxt       = key_r;
    cand_nxt      = cand_r;
    value_nxt     = value_r;
    moved_nxt     = moved_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_r;
    ram_wr_data   = key_r;
    ram_rd_addr   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_word.mode) inside
            MODE_INSERT: begin
              if (count_r < CW'(CAPACITY)) begin
                idx_nxt   = IW'(count_r);
                count_nxt = count_r + CW'(1);
                key_nxt   = in_word.key;
                state_nxt = S_UP_RD;
              end else begin
                out_valid_nxt       = 1'b1;
                out_word_nxt.value  = '0;
                out_word_nxt.status = ST_OVERFLOW;
                out_word_nxt.count  = COUNT_W'(count_r);
              end
            end
            MODE_EXTRACT: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_word_nxt.value  = EMPTY_VALUE;
                out_word_nxt.status = ST_EMPTY;
                out_word_nxt.count  = COUNT_W'(count_r);
              end else begin
                count_nxt = count_r - CW'(1);
                state_nxt = S_EX_RD0;
              end
            end
            MODE_PEEK, MODE_RSVD: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_word_nxt.value  = EMPTY_VALUE;
                out_word_nxt.status = ST_EMPTY;
                out_word_nxt.count  = COUNT_W'(count_r);
              end else begin
                state_nxt = S_PK_RD;
              end
            end
          endcase
        end
      end

      // sift-up keeps the moving key in key_r and shifts parents down
      S_UP_RD: begin
        if (idx_r == '0) begin
          ram_wr_en           = 1'b1;
          out_valid_nxt       = 1'b1;
          out_word_nxt.value  = '0;
          out_word_nxt.status = ST_OK;
          out_word_nxt.count  = COUNT_W'(count_r);
          state_nxt           = S_IDLE;
        end else begin
          ram_rd_addr = pidx;
          state_nxt   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_wr_en = 1'b1;
        if (cmp_gt) begin
          ram_wr_data = ram_rd_data;
          idx_nxt     = pidx;
          state_nxt   = S_UP_RD;
        end else begin
          out_valid_nxt       = 1'b1;
          out_word_nxt.value  = '0;
          out_word_nxt.status = ST_OK;
          out_word_nxt.count  = COUNT_W'(count_r);
          state_nxt           = S_IDLE;
        end
      end

      S_EX_RD0: begin
        ram_rd_addr = '0;
        state_nxt   = S_EX_RDLAST;
      end

      // root arrives; count_r already holds the new count = index of last entry
      S_EX_RDLAST: begin
        value_nxt   = rd_key;
        ram_rd_addr = IW'(count_r);
        if (count_r == '0) begin
          out_valid_nxt       = 1'b1;
          out_word_nxt.value  = rd_key;
          out_word_nxt.status = ST_OK;
          out_word_nxt.count  = COUNT_W'(count_r);
          state_nxt           = S_IDLE;
        end else begin
          state_nxt = S_EX_LAST;
        end
      end

      S_EX_LAST: begin
        key_nxt   = rd_key;
        idx_nxt   = '0;
        state_nxt = S_DN_RDL;
      end

      S_DN_RDL: begin
        if (lidx >= n_ext) begin
          ram_wr_en           = 1'b1;
          out_valid_nxt       = 1'b1;
          out_word_nxt.value  = value_r;
          out_word_nxt.status = ST_OK;
          out_word_nxt.count  = COUNT_W'(count_r);
          state_nxt           = S_IDLE;
        end else begin
          ram_rd_addr = lidx[IW-1:0];
          state_nxt   = S_DN_RDR;
        end
      end

      // left child arrives: larger of key and left child
      S_DN_RDR: begin
        cand_nxt  = cmp_gt ? rd_key : key_r;
        moved_nxt = cmp_gt;
        big_nxt   = lidx[IW-1:0];
        if (ridx < n_ext) begin
          ram_rd_addr = ridx[IW-1:0];
          state_nxt   = S_DN_CMPR;
        end else begin
          state_nxt = S_DN_MOVE;
        end
      end

      S_DN_CMPR: begin
        if (cmp_gt) begin
          cand_nxt  = rd_key;
          moved_nxt = 1'b1;
          big_nxt   = ridx[IW-1:0];
        end
        state_nxt = S_DN_MOVE;
      end

      S_DN_MOVE: begin
        ram_wr_en = 1'b1;
        if (moved_r) begin
          ram_wr_data = cand_r;
          idx_nxt     = big_r;
          state_nxt   = S_DN_RDL;
        end else begin
          out_valid_nxt       = 1'b1;
          out_word_nxt.value  = value_r;
          out_word_nxt.status = ST_OK;
          out_word_nxt.count  = COUNT_W'(count_r);
          state_nxt           = S_IDLE;
        end
      end

      S_PK_RD: begin
        ram_rd_addr = '0;
        state_nxt   = S_PK_GET;
      end

      S_PK_GET: begin
        out_valid_nxt       = 1'b1;
        out_word_nxt.value  = rd_key;
        out_word_nxt.status = ST_OK;
        out_word_nxt.count  = COUNT_W'(count_r);
        state_nxt           = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result shown while sequencer busy");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> state_r != S_IDLE)
    else $error("heap write while idle");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && in_word.mode == MODE_INSERT
     && count_r < CW'(CAPACITY)) |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not bump count");

  a_extract_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && in_word.mode == MODE_EXTRACT
     && count_r != '0) |=> count_r == $past(count_r) - CW'(1))
    else $error("extract did not drop count");
`endif

endmodule

/* hdl/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit keys: insert, extract-max and peek.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Overflow and empty
// results need no heap access: busy stays low and the result word is shown in
// the cycle after the accepting edge. Any other operation raises busy, and its
// single result word appears on out_word with out_valid high for exactly one
// cycle, the cycle in which busy falls. The receiver cannot stall, so it must
// take the word in that cycle. Timing is set by the one-read, one-write heap
// RAM with registered read and one compare per step: peek reads the root;
// insert climbs one level per read-and-compare step until the key is no larger
// than its parent or reaches the root; extract reads the root and, unless that
// empties the heap, the last entry, then descends one level per step, reading
// the left child and, if present, the right child, until no child is larger.
// The store needs no clearing pass: the block is ready right after reset.
module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mhpq_pkg::in_word_t  in_word,
  output logic                busy,
  output logic                out_valid,
  output mhpq_pkg::out_word_t out_word
);

  import mhpq_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  logic             ram_wr_en;
  logic [IW-1:0]    ram_wr_addr;
  logic [KEY_W-1:0] ram_wr_data;
  logic [IW-1:0]    ram_rd_addr;
  logic [KEY_W-1:0] ram_rd_data;

  mhpq_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_word     (in_word),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
